// ----- rtl/tswb_pkg.sv -----
// Shared types and constants for the TCP send window buffer.
// Used by every module under tcp_send_window_buffer_top; no dependencies.
package tswb_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// Register index taken from paddr[2]
	localparam logic REG_INITIAL_SEQNUM = 1'b0;

	typedef enum logic [1:0] {
		REQ_WRITE,
		REQ_READ,
		REQ_ACK,
		REQ_RESTART
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_STALE,
		ST_BEYOND
	} status_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  data_byte;
		logic [11:0] read_index;
		logic [31:0] ack_number;
		logic        last_of_burst;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		status_t     status;
		logic [12:0] free_space;
		logic [11:0] unsent_count;
		logic [31:0] acked_seq;
		logic        last_out;
	} rsp_t;

endpackage

// ----- rtl/tswb_cfg.sv -----
// APB register block: holds the initial sequence number loaded on restart.
// Depends on tswb_pkg.
module tswb_cfg
	import tswb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [31:0]           init_seq
);

	logic [31:0] init_seq_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_seq_q <= '0;
		end else if (wr_en && paddr[2] == REG_INITIAL_SEQNUM) begin
			init_seq_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_INITIAL_SEQNUM) ? init_seq_q : '0;
	assign init_seq = init_seq_q;

endmodule

// ----- rtl/tswb_store.sv -----
// Byte ring storage: single-port synchronous RAM with a registered read.
// Depends on tswb_pkg for the default depth.
module tswb_store
	import tswb_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int PTR_W = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] addr,
	input  logic [7:0]       wdata,
	output logic [7:0]       rdata
);

	logic [7:0] mem [CAPACITY];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tswb_ctrl.sv -----
// Pointer and sequence control for the send ring: decodes each word,
// drives the ring RAM and forms the result. Depends on tswb_pkg.
module tswb_ctrl
	import tswb_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int PTR_W = $clog2(CAPACITY),
	localparam int CNT_W = PTR_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	input  logic [31:0]      init_seq,
	output logic             busy,
	output logic             done,
	output rsp_t             rsp,
	output logic             mem_we,
	output logic [PTR_W-1:0] mem_addr,
	output logic [7:0]       mem_wdata,
	input  logic [7:0]       mem_rdata
);

	logic [31:0]      seq_q, seq_n;
	logic [PTR_W-1:0] ap_q, ap_n;
	logic [PTR_W-1:0] sp_q, sp_n;
	logic [PTR_W-1:0] wp_q, wp_n;

	logic    done_s1;
	logic    is_read_s1;
	status_t status_s1;
	logic    last_s1;

	logic             accept;
	status_t          status_n;
	logic [PTR_W-1:0] off_sp;
	logic [PTR_W-1:0] off_wp;
	logic [CNT_W-1:0] held;
	logic [PTR_W-1:0] idx;
	logic [PTR_W-1:0] off_idx;
	logic [31:0]      target;
	logic [31:0]      delta;
	logic [PTR_W-1:0] newp;

	// One word per cycle: the RAM read lands with the registered result
	assign busy = 1'b0;
	assign accept = start && !busy;

	assign off_sp = sp_q - ap_q;
	assign off_wp = wp_q - ap_q;
	assign held = (wp_q == ap_q) ? CNT_W'(CAPACITY) : {1'b0, off_wp};
	assign idx = PTR_W'(req.read_index);
	assign off_idx = idx - ap_q;
	assign target = req.ack_number - 32'd1;
	assign delta = target - seq_q;
	assign newp = ap_q + PTR_W'(delta);

	always_comb begin
		seq_n = seq_q;
		ap_n = ap_q;
		sp_n = sp_q;
		wp_n = wp_q;
		status_n = ST_OK;
		mem_we = 1'b0;
		mem_addr = idx;
		mem_wdata = req.data_byte;
		if (accept) begin
			unique case (req.req_type)
				REQ_WRITE: begin
					mem_addr = wp_q;
					if (wp_q == ap_q) begin
						status_n = ST_FULL;
					end else begin
						mem_we = 1'b1;
						wp_n = wp_q + PTR_W'(1);
					end
				end
				REQ_READ: begin
					// advance only, never back
					if ({1'b0, off_idx} < held && off_idx > off_sp) begin
						sp_n = idx;
					end
				end
				REQ_ACK: begin
					if (delta == 32'd0 || delta[31]) begin
						status_n = ST_STALE;
					end else if (delta >= 32'(held)) begin
						status_n = ST_BEYOND;
					end else begin
						if (32'(off_sp) < delta) begin
							sp_n = newp;
						end
						ap_n = newp;
						seq_n = target;
					end
				end
				REQ_RESTART: begin
					seq_n = init_seq;
					ap_n = '0;
					sp_n = '0;
					wp_n = PTR_W'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			ap_q <= '0;
			sp_q <= '0;
			wp_q <= PTR_W'(1);
			done_s1 <= 1'b0;
			is_read_s1 <= 1'b0;
			status_s1 <= ST_OK;
			last_s1 <= 1'b0;
		end else begin
			seq_q <= seq_n;
			ap_q <= ap_n;
			sp_q <= sp_n;
			wp_q <= wp_n;
			done_s1 <= accept;
			is_read_s1 <= accept && req.req_type == REQ_READ;
			status_s1 <= status_n;
			last_s1 <= req.last_of_burst;
		end
	end

	// Pointer registers already hold the state after the word being reported
	logic [CNT_W-1:0] free_cnt;
	logic [CNT_W-1:0] unsent_cnt;

	assign free_cnt = CNT_W'(CAPACITY) - held;
	assign unsent_cnt = held - CNT_W'(1) - {1'b0, off_sp};

	assign done = done_s1;
	assign rsp.read_byte = is_read_s1 ? mem_rdata : 8'd0;
	assign rsp.status = status_s1;
	assign rsp.free_space = 13'(free_cnt);
	assign rsp.unsent_count = 12'(unsent_cnt);
	assign rsp.acked_seq = seq_q;
	assign rsp.last_out = last_s1;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept))
		else $error("result strobe does not follow accepted word");

	a_sent_inside_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, off_sp} < held)
		else $error("sent pointer outside held bytes");

	a_refused_write_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_WRITE && wp_q == ap_q) |=> $stable(wp_q))
		else $error("refused write moved write pointer");

	a_bad_ack_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s1 && (status_s1 == ST_STALE || status_s1 == ST_BEYOND))
		|-> (ap_q == $past(ap_q) && seq_q == $past(seq_q)))
		else $error("rejected ack changed acked state");

endmodule

// ----- rtl/tcp_send_window_buffer_top.sv -----
// Top level of the TCP send window buffer: APB register, control, ring RAM.
// Depends on tswb_pkg, tswb_cfg, tswb_ctrl and tswb_store.
//
//  channel   handshake                       payload
//  request   start in, busy out              req   (req_t)
//  result    done out, one cycle             rsp   (rsp_t)
//  config    psel/penable/pwrite, pready     paddr, pwdata, prdata
//
// A word is taken in every cycle; its result shows in the following cycle, as
// set by the registered read of the ring RAM.
// busy stays low: no word waits on another.
// Reset zeroes ack and sent pointers, sets the write pointer to 1 and clears
// acked and initial sequence; RAM keeps its contents and needs no clearing pass.
// The result cannot be stalled; it is valid only in the done cycle.
module tcp_send_window_buffer_top
	import tswb_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int PTR_W = $clog2(CAPACITY);

	logic [31:0]      init_seq;
	logic             mem_we;
	logic [PTR_W-1:0] mem_addr;
	logic [7:0]       mem_wdata;
	logic [7:0]       mem_rdata;

	tswb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.init_seq (init_seq)
	);

	tswb_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.init_seq  (init_seq),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	tswb_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

// ----- tb/tswb_ring_checker.sv -----
// Checker for tcp_send_window_buffer_top: mirrors the send ring, predicts each
// result word and compares it with the block's output. Depends on tswb_pkg.
// Also exports a state snapshot that the stimulus uses to aim reads and acks.
module tswb_ring_checker
	import tswb_pkg::*;
#(
	parameter int CAP = CAPACITY_DEF,
	parameter int IW = $clog2(CAP)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  req_t                  req,
	input  logic                  done,
	input  rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    fails,
	output int                    pending,
	output int                    words,
	output logic [3:0][31:0]      tally,
	output logic [31:0]           snap_seq,
	output logic [IW-1:0]         snap_ack_ptr,
	output logic [IW-1:0]         snap_wr_ptr,
	output logic [CAP-1:0]        filled
);

	localparam logic [IW:0] RING_FULL = (IW+1)'(CAP);

	logic [7:0]     byte_ring [CAP];
	logic [CAP-1:0] written;
	logic [31:0]    acked_seq;
	logic [31:0]    seed_seq;
	logic [IW-1:0]  ack_ptr;
	logic [IW-1:0]  sent_ptr;
	logic [IW-1:0]  wr_ptr;
	rsp_t           awaited_rsp [$];

	function automatic logic [IW-1:0] ring_dist(logic [IW-1:0] p);
		return p - ack_ptr;
	endfunction

	function automatic logic [IW:0] ring_held();
		return (wr_ptr == ack_ptr) ? RING_FULL : {1'b0, ring_dist(wr_ptr)};
	endfunction

	// Apply one request word to the mirrored ring and return its result word.
	function automatic rsp_t ring_response(req_t w);
		rsp_t          r;
		logic [IW-1:0] idx;
		logic [31:0]   delta;
		logic [IW:0]   held;
		r = '0;
		case (w.req_type)
			REQ_WRITE: begin
				if (ring_held() == RING_FULL) begin
					r.status = ST_FULL;
				end else begin
					byte_ring[wr_ptr] = w.data_byte;
					written[wr_ptr] = 1'b1;
					wr_ptr = wr_ptr + IW'(1);
				end
			end
			REQ_READ: begin
				idx = w.read_index[IW-1:0];
				r.read_byte = byte_ring[idx];
				// advance only inside the written window and only forward
				if ({1'b0, ring_dist(idx)} < ring_held() &&
					ring_dist(idx) > ring_dist(sent_ptr))
					sent_ptr = idx;
			end
			REQ_ACK: begin
				delta = w.ack_number - 32'd1 - acked_seq;
				if (delta == 32'd0 || delta[31]) begin
					r.status = ST_STALE;
				end else if (delta >= 32'(ring_held())) begin
					r.status = ST_BEYOND;
				end else begin
					if (32'(ring_dist(sent_ptr)) < delta)
						sent_ptr = ack_ptr + delta[IW-1:0];
					ack_ptr = ack_ptr + delta[IW-1:0];
					acked_seq = w.ack_number - 32'd1;
				end
			end
			REQ_RESTART: begin
				acked_seq = seed_seq;
				ack_ptr = '0;
				sent_ptr = '0;
				wr_ptr = IW'(1);
			end
		endcase
		held = ring_held();
		r.free_space = 13'(RING_FULL - held);
		r.unsent_count = 12'(held - (IW+1)'(1) - {1'b0, ring_dist(sent_ptr)});
		r.acked_seq = acked_seq;
		r.last_out = w.last_of_burst;
		return r;
	endfunction

	function automatic int field_diff(string field, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp;
		if (!arst_n) begin
			awaited_rsp.delete();
			written = '0;
			acked_seq = '0;
			seed_seq = '0;
			ack_ptr = '0;
			sent_ptr = '0;
			wr_ptr = IW'(1);
			fails = 0;
			words = 0;
			tally = '0;
			pending <= 0;
			snap_seq <= '0;
			snap_ack_ptr <= '0;
			snap_wr_ptr <= IW'(1);
			filled <= '0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_INITIAL_SEQNUM)
				seed_seq = pwdata;
			if (start && !busy)
				awaited_rsp.push_back(ring_response(req));
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: result word with nothing expected, got %0h", $time, rsp);
					fails++;
				end else begin
					exp = awaited_rsp.pop_front();
					fails += field_diff("read_byte", exp.read_byte, rsp.read_byte);
					fails += field_diff("status", exp.status, rsp.status);
					fails += field_diff("free_space", exp.free_space, rsp.free_space);
					fails += field_diff("unsent_count", exp.unsent_count, rsp.unsent_count);
					fails += field_diff("acked_seq", exp.acked_seq, rsp.acked_seq);
					fails += field_diff("last_out", exp.last_out, rsp.last_out);
					tally[exp.status] = tally[exp.status] + 1;
					words++;
				end
			end
			pending <= awaited_rsp.size();
			snap_seq <= acked_seq;
			snap_ack_ptr <= ack_ptr;
			snap_wr_ptr <= wr_ptr;
			filled <= written;
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for tcp_send_window_buffer_top: clock, reset, APB writes and
// request stimulus. Depends on tswb_pkg, the top and tswb_ring_checker, which does the checking.
module tb;
	import tswb_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int IW = $clog2(CAP);
	localparam int LIMIT = 200000;
	localparam int RANDOM_WORDS = 500;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	req_t                  req = '0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  rsp;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int               fails;
	int               pending;
	int               words;
	logic [3:0][31:0] tally;
	logic [31:0]      snap_seq;
	logic [IW-1:0]    snap_ack_ptr;
	logic [IW-1:0]    snap_wr_ptr;
	logic [CAP-1:0]   filled;

	int idle_pct = 0;
	int cycle_count = 0;

	tcp_send_window_buffer_top #(.CAPACITY(CAP)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tswb_ring_checker #(.CAP(CAP)) i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .fails(fails),
		.pending(pending), .words(words), .tally(tally), .snap_seq(snap_seq),
		.snap_ack_ptr(snap_ack_ptr), .snap_wr_ptr(snap_wr_ptr), .filled(filled)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", LIMIT, pending);
			$display("tcp_send_window_buffer_top regression: fail");
			$finish;
		end
	end

	function automatic req_t mk(req_kind_t kind, logic [7:0] b, logic [11:0] idx,
		logic [31:0] ack, logic last);
		req_t w;
		w.req_type = kind;
		w.data_byte = b;
		w.read_index = idx;
		w.ack_number = ack;
		w.last_of_burst = last;
		return w;
	endfunction

	// Idle at random, then hold the word until it is taken.
	task automatic put_word(input req_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending and wait until every expected word has come back.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_INITIAL_SEQNUM, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		req_t          w;
		int            ph;
		int            n;
		int            h;
		int            roll;
		int            idle_steps [3];
		logic [IW-1:0] gap;
		idle_steps = '{25, 66, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = idle_steps[0];
		@(posedge clk);

		// small ring walk with the reset seed
		put_word(mk(REQ_WRITE, 8'h00, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_WRITE, 8'hff, 12'd0, 32'd0, 1'b1));
		put_word(mk(REQ_WRITE, 8'ha5, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_READ, 8'h00, 12'd1, 32'd0, 1'b0));
		put_word(mk(REQ_READ, 8'h00, 12'd3, 32'd0, 1'b1));
		put_word(mk(REQ_READ, 8'h00, 12'd2, 32'd0, 1'b0));       // behind sent: hold
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'd1, 1'b0));        // no progress
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'd0, 1'b0));        // wraps behind
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'hffff_ffff, 1'b0));
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'd5, 1'b0));        // one past window
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'd3, 1'b0));        // sent stays ahead
		put_word(mk(REQ_WRITE, 8'h5a, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_WRITE, 8'h3c, 12'd0, 32'd0, 1'b1));
		put_word(mk(REQ_READ, 8'h00, 12'd1, 32'd0, 1'b0));       // written but outside window
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'd6, 1'b0));        // drags sent along
		put_word(mk(REQ_RESTART, 8'h00, 12'd0, 32'd0, 1'b0));

		// acked sequence crossing the 32-bit wrap
		settle();
		write_seed(32'hffff_fffe);
		put_word(mk(REQ_RESTART, 8'h00, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_WRITE, 8'h11, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_WRITE, 8'h22, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_WRITE, 8'h33, 12'd0, 32'd0, 1'b1));
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'd1, 1'b0));
		put_word(mk(REQ_READ, 8'h00, 12'd3, 32'd0, 1'b1));

		// fill the ring to the brim, then push a few refused writes
		settle();
		write_seed(32'h8000_0000);
		put_word(mk(REQ_RESTART, 8'h00, 12'd0, 32'd0, 1'b0));
		repeat (CAP + 2)
			put_word(mk(REQ_WRITE, 8'($urandom), 12'd0, 32'd0, 1'($urandom)));
		put_word(mk(REQ_READ, 8'h00, 12'h800, 32'd0, 1'b0));
		put_word(mk(REQ_READ, 8'h00, 12'hfff, 32'd0, 1'b1));
		put_word(mk(REQ_ACK, 8'h00, 12'd0, 32'h8000_0002, 1'b0));
		put_word(mk(REQ_WRITE, 8'h77, 12'd0, 32'd0, 1'b0));
		put_word(mk(REQ_READ, 8'h00, 12'h000, 32'd0, 1'b0));

		// random traffic aimed at the live window, with some noise
		for (ph = 0; ph < 3; ph++) begin
			settle();
			idle_pct = idle_steps[ph];
			write_seed((ph == 0) ? 32'hffff_ffff : (ph == 1) ? 32'($urandom) : 32'h0);
			put_word(mk(REQ_RESTART, 8'h00, 12'd0, 32'd0, 1'b0));
			for (n = 0; n < RANDOM_WORDS; n++) begin
				gap = snap_wr_ptr - snap_ack_ptr;
				h = (gap == '0) ? CAP : int'(gap);
				w = mk(REQ_WRITE, 8'($urandom), 12'($urandom), 32'($urandom), 1'($urandom));
				roll = $urandom_range(99);
				if (roll < 3) begin
					w.req_type = REQ_RESTART;
				end else if (roll >= 48 && roll < 73) begin
					w.req_type = REQ_READ;
					if (roll < 68)
						w.read_index = snap_ack_ptr + 12'($urandom_range(h - 1));
					// never touch a slot that was not written yet
					if (!filled[w.read_index])
						w.req_type = REQ_WRITE;
				end else if (roll >= 73) begin
					w.req_type = REQ_ACK;
					case (roll % 8)
						0: ;
						1: w.ack_number = snap_seq + 32'd1;
						2: w.ack_number = snap_seq + 32'(h) + 32'd1;
						3: w.ack_number = snap_seq - 32'($urandom_range(1000));
						4: w.ack_number = snap_seq + 32'(h);
						default: w.ack_number = snap_seq + 32'd2 +
							32'($urandom_range((h > 17) ? 15 : ((h > 2) ? h - 2 : 0)));
					endcase
				end
				put_word(w);
			end
		end

		settle();
		$display("%0d words checked: directed walk, full ring and three random idle settings",
			words);
		$display("status mix: ok %0d, write refused %0d, ack stale %0d, ack beyond %0d",
			tally[ST_OK], tally[ST_FULL], tally[ST_STALE], tally[ST_BEYOND]);
		if (fails == 0) begin
			$display("tcp_send_window_buffer_top regression: pass");
		end else begin
			$display("%0d mismatches", fails);
			$display("tcp_send_window_buffer_top regression: fail");
		end
		$finish;
	end

endmodule
